[design/scheduled_hysteresis_thermostat_top_assert.svh]
// ----------------------------------------------------------------------------
// Scheduled hysteresis thermostat assertion macros
// Concurrent checks used by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_HYSTERESIS_THERMOSTAT_TOP_ASSERT_SVH
`define SCHEDULED_HYSTERESIS_THERMOSTAT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// check a property outside reset
`define SHT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every edge, reset included
`define SHT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[design/sht_pkg.sv]
// ----------------------------------------------------------------------------
// Scheduled hysteresis thermostat package
// Shared constants, item layouts, command/status types and the slot match.
// ----------------------------------------------------------------------------
`default_nettype none

package sht_pkg;

    localparam int SLOTS_PER_DAY = 6;
    localparam int DAYS          = 7;
    localparam int ENTRIES       = DAYS * SLOTS_PER_DAY;
    localparam int ADDR_W        = $clog2(ENTRIES);
    localparam int IDX_W         = $clog2(SLOTS_PER_DAY);
    localparam int MIN_PER_HOUR  = 60;
    localparam int START_W       = 11;
    localparam int TEMP_W        = 15;
    localparam int DELTA_W       = 11;
    localparam int WIDE_W        = TEMP_W + 2;
    localparam int IN_W          = 64;
    localparam int OUT_W         = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS_PER_DAY - 1);

    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE        = 2'd0,
        CFG_MANUAL_MODE   = 2'd1,
        CFG_MANUAL_TARGET = 2'd2,
        CFG_HYST_DELTA    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } state_t;

    // first member sits in the top bits
    typedef struct packed {
        logic [2:0]                pad;
        logic signed [TEMP_W-1:0]  slot_target;
        logic [START_W-1:0]        slot_start;
        logic [2:0]                slot_index;
        logic [2:0]                slot_day;
        logic signed [TEMP_W-1:0]  current_temp;
        logic [5:0]                minute;
        logic [4:0]                hour;
        logic [2:0]                day_of_week;
    } in_item_t;

    typedef struct packed {
        logic [3:0]                pad;
        logic [2:0]                matched_slot;
        logic                      slot_matched;
        logic signed [TEMP_W-1:0]  target_temp;
        logic                      heat_on;
    } out_item_t;

    typedef struct packed {
        logic [START_W-1:0]        start;
        logic signed [TEMP_W-1:0]  target;
    } slot_t;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             finish;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic out_free;
    } status_t;

    // interval from a to b, both ends included, wrapping past midnight when a > b
    function automatic logic slot_match(input logic [START_W-1:0] a,
                                        input logic [START_W-1:0] b,
                                        input logic [START_W-1:0] now);
        logic r;
        if (a > b) begin
            r = (now >= a) || (now <= b);
        end else begin
            r = (now >= a) && (now <= b);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/sht_ctrl.sv]
// ----------------------------------------------------------------------------
// Thermostat controller
// Sequences accept, slot scan and result hand-off for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scheduled_hysteresis_thermostat_top_assert.svh"

module sht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sht_pkg::status_t  st,
    output sht_pkg::cmd_t     cmd
);
    import sht_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                cnt_next = '0;
                if (s_tvalid) begin
                    state_next = st.need_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = cnt_reg;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_LAST;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_LAST: begin
                // last slot read lands in the datapath this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SHT_ASSERT(a_finish_free, aclk, aresetn, cmd.finish |-> st.out_free, "result loaded while output busy")
    `SHT_ASSERT(a_load_busy, aclk, aresetn, cmd.load |=> (state_reg != ST_IDLE), "accepted item left no work")
    `SHT_ASSERT(a_last_after_scan, aclk, aresetn, (state_reg == ST_LAST) |-> $past((state_reg == ST_SCAN) && (cnt_reg == LAST_IDX)), "scan ended early")
    `SHT_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_IDLE), "reset did not return to idle")

endmodule

`default_nettype wire

[design/sht_dp.sv]
// ----------------------------------------------------------------------------
// Thermostat datapath
// Config registers, slot memory, scan compare, hysteresis and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sht_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sht_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [sht_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [sht_pkg::IN_W-1:0]          s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sht_pkg::OUT_W-1:0]         m_tdata,
    input  sht_pkg::cmd_t                     cmd,
    output sht_pkg::status_t                  st
);
    import sht_pkg::*;

    in_item_t                 in_item;
    in_item_t                 item_reg;
    op_t                      op_reg;
    logic [START_W-1:0]       now_reg;

    logic                     enable_reg;
    logic                     manual_reg;
    logic signed [TEMP_W-1:0] mtarget_reg;
    logic [DELTA_W-1:0]       delta_reg;

    slot_t                    mem [ENTRIES];
    logic [ENTRIES-1:0]       valid_reg;
    slot_t                    rd_data_reg;
    logic                     rd_hit_reg;
    logic                     rq_vld_reg;
    logic [IDX_W-1:0]         rq_idx_reg;
    logic [ADDR_W-1:0]        rd_addr, wr_addr;
    logic                     wr_ok;
    slot_t                    wr_slot, cur_slot;

    slot_t                    prev_reg;
    logic [START_W-1:0]       start0_reg;
    logic                     found_reg;
    logic signed [TEMP_W-1:0] tgt_reg;
    logic [IDX_W-1:0]         midx_reg;
    logic                     hit_a, hit_w;

    logic                     heat_reg, heat_next;
    out_item_t                out_reg, out_next;
    logic                     m_valid_reg;
    logic signed [TEMP_W-1:0] tgt_sel;
    logic signed [WIDE_W-1:0] temp_s, tgt_s, delta_s, hi_s, lo_s;

    assign in_item = in_item_t'(s_tdata);

    assign st.need_scan = (op_t'(s_tuser) == OP_CHECK) && enable_reg && !manual_reg
                          && (in_item.day_of_week < 3'(DAYS));
    assign st.out_free  = !m_valid_reg || m_tready;

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
            op_reg   <= op_t'(s_tuser);
            now_reg  <= START_W'({6'd0, in_item.hour} * START_W'(MIN_PER_HOUR))
                        + START_W'(in_item.minute);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b1;
            manual_reg  <= 1'b0;
            mtarget_reg <= '0;
            delta_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_index))
                CFG_ENABLE:        enable_reg  <= cfg_wr_data[0];
                CFG_MANUAL_MODE:   manual_reg  <= cfg_wr_data[0];
                CFG_MANUAL_TARGET: mtarget_reg <= cfg_wr_data[TEMP_W-1:0];
                CFG_HYST_DELTA:    delta_reg   <= cfg_wr_data[DELTA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // slot store
    assign rd_addr = ADDR_W'(item_reg.day_of_week * SLOTS_PER_DAY) + ADDR_W'(cmd.rd_idx);
    assign wr_addr = ADDR_W'(item_reg.slot_day * SLOTS_PER_DAY) + ADDR_W'(item_reg.slot_index);
    assign wr_ok   = (item_reg.slot_day < 3'(DAYS)) && (item_reg.slot_index < 3'(SLOTS_PER_DAY));
    assign wr_slot = '{start: item_reg.slot_start, target: item_reg.slot_target};

    always_ff @(posedge aclk) begin
        if (cmd.finish && (op_reg == OP_WRITE) && wr_ok) begin
            mem[wr_addr] <= wr_slot;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rq_vld_reg <= 1'b0;
        end else begin
            if (cmd.finish && (op_reg == OP_WRITE) && wr_ok) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rq_vld_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_hit_reg <= valid_reg[rd_addr];
        end
        rq_idx_reg <= cmd.rd_idx;
    end

    // never-written entries read as zero
    assign cur_slot = rd_hit_reg ? rd_data_reg : '0;
    assign hit_a    = slot_match(prev_reg.start, cur_slot.start, now_reg);
    assign hit_w    = slot_match(cur_slot.start, start0_reg, now_reg);

    // scan: slot k-1 is judged when slot k arrives; the last slot also against slot 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
        end else if (rq_vld_reg && (rq_idx_reg != '0) && !found_reg) begin
            if (hit_a || ((rq_idx_reg == LAST_IDX) && hit_w)) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tgt_reg  <= '0;
            midx_reg <= '0;
        end else if (rq_vld_reg) begin
            prev_reg <= cur_slot;
            if (rq_idx_reg == '0) begin
                start0_reg <= cur_slot.start;
            end else if (!found_reg) begin
                if (hit_a) begin
                    tgt_reg  <= prev_reg.target;
                    midx_reg <= rq_idx_reg - IDX_W'(1);
                end else if ((rq_idx_reg == LAST_IDX) && hit_w) begin
                    tgt_reg  <= cur_slot.target;
                    midx_reg <= rq_idx_reg;
                end
            end
        end
    end

    // hysteresis decision
    assign tgt_sel = manual_reg ? mtarget_reg : tgt_reg;
    assign temp_s  = {{2{item_reg.current_temp[TEMP_W-1]}}, item_reg.current_temp};
    assign tgt_s   = {{2{tgt_sel[TEMP_W-1]}}, tgt_sel};
    assign delta_s = {{(WIDE_W - DELTA_W){1'b0}}, delta_reg};
    assign hi_s    = tgt_s + delta_s;
    assign lo_s    = tgt_s - delta_s;

    always_comb begin
        heat_next = heat_reg;
        out_next  = '0;
        case (op_reg)
            OP_WRITE: begin
                out_next.heat_on = heat_reg;
            end
            default: begin
                if (!enable_reg) begin
                    heat_next = 1'b0;
                end else begin
                    if (temp_s >= hi_s) begin
                        heat_next = 1'b0;
                    end
                    if (temp_s <= lo_s) begin
                        heat_next = 1'b1;
                    end
                    out_next.target_temp = tgt_sel;
                    if (!manual_reg) begin
                        out_next.slot_matched = found_reg;
                        out_next.matched_slot = 3'(midx_reg);
                    end
                end
                out_next.heat_on = heat_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            heat_reg    <= heat_next;
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

[design/scheduled_hysteresis_thermostat_top.sv]
// ----------------------------------------------------------------------------
// Scheduled hysteresis thermostat
// Weekly slot schedule with a hysteresis heat flag.
//
//   channel  direction  handshake           payload
//   s_       in         s_tvalid/s_tready   s_tdata, s_tuser (operation)
//   m_       out        m_tvalid/m_tready   m_tdata
//   cfg_     in         cfg_wr_en           cfg_wr_index, cfg_wr_data
//
// A scheduled check makes one slot memory read per cycle for each slot of the
// day, lets the last read land, then takes the hysteresis decision and loads
// the output register. Writes, manual and inactive checks and checks of a day
// out of range skip the scan. One item is in work at a time; the output
// register lets the next item enter while a result waits. A stalled m_tready
// holds the result and the block in the decision cycle. Reset is synchronous;
// the slot store is cleared at once through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_hysteresis_thermostat_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sht_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [sht_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // day_of_week, hour, minute, current_temp, slot_day, slot_index,
    // slot_start, slot_target, zero pad
    input  logic [sht_pkg::IN_W-1:0]       s_tdata,
    // operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // heat_on, target_temp, slot_matched, matched_slot, zero pad
    output logic [sht_pkg::OUT_W-1:0]      m_tdata
);
    import sht_pkg::*;

    cmd_t    cmd;
    status_t st;

    sht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sht_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

`default_nettype wire

[tb/sv/scheduled_hysteresis_thermostat_top_tb.sv]
// ----------------------------------------------------------------------------
// Scheduled hysteresis thermostat testbench
// Streams schedule writes and temperature checks into the block under several
// register settings. A local copy of the slot store and heat flag predicts
// every result, and each result is compared field by field in arrival order.
// Both stream sides idle at random. Twice the receiver holds off long enough
// to back the block up into its input.
// ----------------------------------------------------------------------------
module scheduled_hysteresis_thermostat_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sht_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_ITEMS    = 240;
    localparam int RANDOM_PHASES  = 8;

    typedef struct {
        op_t      op;
        in_item_t data;
    } stim_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    cfg_idx_t              cfg_wr_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata      = '0;
    logic                  s_tuser      = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    // predicted block state
    logic                     therm_enable;
    logic                     therm_manual;
    logic signed [TEMP_W-1:0] therm_manual_target;
    logic [DELTA_W-1:0]       therm_delta;
    logic                     heat_state;
    logic [START_W-1:0]       sched_start  [DAYS][SLOTS_PER_DAY];
    logic signed [TEMP_W-1:0] sched_target [DAYS][SLOTS_PER_DAY];

    stim_t     pending_items[$];
    out_item_t expected_status[$];

    stim_t     drv_item;
    int        drv_gap      = 0;
    int        stall_left   = 0;
    int        hold_left    = 0;
    int        results_seen = 0;
    int        fail_count   = 0;
    int        quiet_cycles = 0;
    bit        idle_on      = 1'b0;
    out_item_t mon_got;
    out_item_t mon_want;

    always #6 aclk = ~aclk;

    scheduled_hysteresis_thermostat_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_temp();
        if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 20000)) - 5000;
        return int'($urandom_range(0, 32767)) - 16384;
    endfunction

    // Advance the thermostat state by one item and return its result.
    function automatic out_item_t predict_status(input stim_t it);
        out_item_t  res;
        logic [2:0] d;
        int         target;
        int         temp;
        int         now;
        int         lo;
        int         hi;
        int         nx;
        logic       hit;
        res    = '0;
        target = 0;
        d      = it.data.day_of_week;
        if (it.op == OP_WRITE) begin
            if (it.data.slot_day < DAYS && it.data.slot_index < SLOTS_PER_DAY) begin
                sched_start[it.data.slot_day][it.data.slot_index]  = it.data.slot_start;
                sched_target[it.data.slot_day][it.data.slot_index] = it.data.slot_target;
            end
        end else if (!therm_enable) begin
            heat_state = 1'b0;
        end else begin
            temp = int'(it.data.current_temp);
            if (therm_manual) begin
                target = int'(therm_manual_target);
            end else if (d < DAYS) begin
                now = int'(it.data.hour) * MIN_PER_HOUR + int'(it.data.minute);
                for (int i = 0; i < SLOTS_PER_DAY; i++) begin
                    nx  = (i + 1 < SLOTS_PER_DAY) ? i + 1 : 0;
                    lo  = int'(sched_start[d][i]);
                    hi  = int'(sched_start[d][nx]);
                    // interval wraps past midnight when the next start is earlier
                    hit = (lo > hi) ? (now >= lo || now <= hi) : (now >= lo && now <= hi);
                    if (hit && !res.slot_matched) begin
                        target           = int'(sched_target[d][i]);
                        res.slot_matched = 1'b1;
                        res.matched_slot = 3'(i);
                    end
                end
            end
            if (temp >= target + int'(therm_delta)) heat_state = 1'b0;
            // the turn-on test is applied last and wins
            if (temp <= target - int'(therm_delta)) heat_state = 1'b1;
            res.target_temp = target[TEMP_W-1:0];
        end
        res.heat_on = heat_state;
        return res;
    endfunction

    // Unused fields other than the zero pad carry random bits.
    function automatic void queue_write(input logic [2:0] d, input logic [2:0] idx,
                                        input logic [START_W-1:0] start,
                                        input logic signed [TEMP_W-1:0] tgt);
        stim_t it;
        it.op              = OP_WRITE;
        it.data            = in_item_t'({$urandom, $urandom});
        it.data.pad        = '0;
        it.data.slot_day   = d;
        it.data.slot_index = idx;
        it.data.slot_start = start;
        it.data.slot_target = tgt;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_check(input logic [2:0] d, input logic [4:0] hr,
                                        input logic [5:0] mn,
                                        input logic signed [TEMP_W-1:0] temp);
        stim_t it;
        it.op               = OP_CHECK;
        it.data             = in_item_t'({$urandom, $urandom});
        it.data.pad         = '0;
        it.data.day_of_week = d;
        it.data.hour        = hr;
        it.data.minute      = mn;
        it.data.current_temp = temp;
        pending_items.push_back(it);
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            CFG_ENABLE:        therm_enable        = val[0];
            CFG_MANUAL_MODE:   therm_manual        = val[0];
            CFG_MANUAL_TARGET: therm_manual_target = val[TEMP_W-1:0];
            default:           therm_delta         = val[DELTA_W-1:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Upper data bits are random; the block must mask them.
    task automatic set_regs(input logic en, input logic man,
                            input logic signed [TEMP_W-1:0] mt,
                            input logic [DELTA_W-1:0] dl);
        logic [CFG_DATA_W-1:0] v;
        v    = CFG_DATA_W'($urandom);
        v[0] = en;
        write_reg(CFG_ENABLE, v);
        v    = CFG_DATA_W'($urandom);
        v[0] = man;
        write_reg(CFG_MANUAL_MODE, v);
        write_reg(CFG_MANUAL_TARGET, mt);
        v    = CFG_DATA_W'($urandom);
        v[DELTA_W-1:0] = dl;
        write_reg(CFG_HYST_DELTA, v);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_status.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sender: offer queued items, idling between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status.push_back(predict_status(drv_item));
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    drv_item = pending_items.pop_front();
                    s_tdata  <= drv_item.data;
                    s_tuser  <= drv_item.op;
                    s_tvalid <= 1'b1;
                    drv_gap  = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                mon_got = out_item_t'(m_tdata);
                if (expected_status.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", m_tdata);
                    fail_count++;
                end else begin
                    mon_want = expected_status.pop_front();
                    if (mon_got.heat_on !== mon_want.heat_on
                        || mon_got.target_temp !== mon_want.target_temp
                        || mon_got.slot_matched !== mon_want.slot_matched
                        || mon_got.matched_slot !== mon_want.matched_slot) begin
                        if (fail_count < 10) begin
                            $display("result %0d: expected heat=%0b target=%0d match=%0b slot=%0d",
                                     results_seen, mon_want.heat_on,
                                     $signed(mon_want.target_temp), mon_want.slot_matched,
                                     mon_want.matched_slot);
                            $display("            got      heat=%0b target=%0d match=%0b slot=%0d",
                                     mon_got.heat_on, $signed(mon_got.target_temp),
                                     mon_got.slot_matched, mon_got.matched_slot);
                        end
                        fail_count++;
                    end
                end
                results_seen++;
                // back the block up into its input
                if (results_seen == 300 || results_seen == 1400) hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int         phase_count;
        int         r;
        int         now;
        int         temp;
        int         base;
        logic [2:0] d;
        logic [2:0] idx;
        logic [4:0] hr;
        logic [5:0] mn;
        int         starts[$];

        therm_enable        = 1'b1;
        therm_manual        = 1'b0;
        therm_manual_target = '0;
        therm_delta         = '0;
        heat_state          = 1'b0;
        for (int i = 0; i < DAYS; i++) begin
            for (int j = 0; j < SLOTS_PER_DAY; j++) begin
                sched_start[i][j]  = '0;
                sched_target[i][j] = '0;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Cleared store: all starts zero, only midnight matches.
        queue_check(3'd0, 5'd0, 6'd0, 15'sd100);
        queue_write(3'd2, 3'd0, 11'd360, 15'sd2000);
        queue_write(3'd2, 3'd1, 11'd480, 15'sd1800);
        queue_write(3'd2, 3'd2, 11'd720, 15'sd2100);
        queue_write(3'd2, 3'd3, 11'd1020, -15'sd5000);
        queue_write(3'd2, 3'd4, 11'd1320, 15'sd15000);
        queue_write(3'd2, 3'd5, 11'd1380, 15'sd1600);
        // out-of-range day and slot: dropped
        queue_write(3'd7, 3'd0, 11'd100, 15'sd700);
        queue_write(3'd1, 3'd6, 11'd100, 15'sd700);
        // start beyond the day is stored as is
        queue_write(3'd3, 3'd0, 11'd2047, -15'sd16384);
        queue_write(3'd4, 3'd2, 11'd600, 15'sd16383);
        queue_check(3'd2, 5'd6, 6'd0, 15'sd1999);
        queue_check(3'd2, 5'd8, 6'd0, 15'sd1800);
        queue_check(3'd2, 5'd23, 6'd59, 15'sd16383);
        queue_check(3'd2, 5'd0, 6'd0, -15'sd16384);
        queue_check(3'd2, 5'd13, 6'd30, 15'sd2100);
        queue_check(3'd2, 5'd31, 6'd63, 15'sd0);
        queue_check(3'd7, 5'd10, 6'd0, 15'sd5);
        queue_check(3'd3, 5'd0, 6'd0, -15'sd16384);
        queue_check(3'd4, 5'd15, 6'd0, 15'sd16383);
        wait_idle();

        set_regs(1'b1, 1'b0, 15'sd0, 11'd2000);
        queue_check(3'd2, 5'd6, 6'd30, 15'sd4000);
        queue_check(3'd2, 5'd6, 6'd30, 15'sd3999);
        queue_check(3'd2, 5'd6, 6'd30, 15'sd0);
        wait_idle();

        set_regs(1'b1, 1'b1, -15'sd16384, 11'd2047);
        queue_check(3'd5, 5'd9, 6'd0, 15'sd16383);
        wait_idle();
        write_reg(CFG_MANUAL_TARGET, 15'sd16383);
        queue_check(3'd5, 5'd9, 6'd0, -15'sd16384);
        wait_idle();

        // inactive: heat forced off
        set_regs(1'b0, 1'b0, 15'sd0, 11'd0);
        queue_check(3'd2, 5'd6, 6'd30, -15'sd16384);
        queue_write(3'd6, 3'd5, 11'd1439, 15'sd500);
        wait_idle();

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            case (k)
                0: set_regs(1'b1, 1'b0, 15'sd0, 11'd0);
                1: set_regs(1'b1, 1'b0, TEMP_W'($urandom), 11'd2047);
                2: set_regs(1'b1, 1'b1, -15'sd16384, 11'd0);
                3: set_regs(1'b1, 1'b0, TEMP_W'($urandom),
                            DELTA_W'($urandom_range(0, 2000)));
                4: set_regs(1'b1, 1'b1, 15'sd16383, DELTA_W'($urandom));
                5: set_regs(1'b0, 1'($urandom), TEMP_W'($urandom), DELTA_W'($urandom));
                6: set_regs(1'b1, 1'b0, TEMP_W'(rand_temp()), 11'd300);
                default: set_regs(1'b1, 1'b1, TEMP_W'(rand_temp()), 11'd150);
            endcase
            idle_on     = (k % 4 != 2);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    // program a whole day with rising start minutes
                    d = 3'($urandom_range(0, DAYS - 1));
                    starts.delete();
                    for (int i = 0; i < SLOTS_PER_DAY; i++) begin
                        starts.push_back($urandom_range(0, 1439));
                    end
                    starts.sort();
                    for (int i = 0; i < SLOTS_PER_DAY; i++) begin
                        queue_write(d, 3'(i), START_W'(starts[i]), TEMP_W'(rand_temp()));
                    end
                    phase_count += SLOTS_PER_DAY;
                end else if (r < 22) begin
                    d   = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, DAYS - 1));
                    idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, SLOTS_PER_DAY - 1));
                    queue_write(d, idx,
                                START_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 1439)
                                                                      : $urandom_range(0, 2047)),
                                TEMP_W'(rand_temp()));
                    phase_count++;
                end else begin
                    d   = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, DAYS - 1));
                    idx = 3'($urandom_range(0, SLOTS_PER_DAY - 1));
                    if ($urandom_range(0, 1) == 1) begin
                        // land on or beside a slot boundary
                        now = int'(sched_start[(d < DAYS) ? d : 3'd0][idx])
                              + int'($urandom_range(0, 2)) - 1;
                        if (now < 0) now = 0;
                        if (now > 1439) now = 1439;
                        hr = 5'(now / MIN_PER_HOUR);
                        mn = 6'(now % MIN_PER_HOUR);
                    end else if ($urandom_range(0, 9) == 0) begin
                        hr = 5'($urandom_range(0, 31));
                        mn = 6'($urandom_range(0, 63));
                    end else begin
                        hr = 5'($urandom_range(0, 23));
                        mn = 6'($urandom_range(0, 59));
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        // hover around the likely target to work the band
                        base = therm_manual ? int'(therm_manual_target)
                             : (d < DAYS) ? int'(sched_target[d][idx]) : 0;
                        temp = base + int'($urandom_range(0, 5000)) - 2500;
                        if (temp < -16384) temp = -16384;
                        if (temp > 16383) temp = 16383;
                    end else begin
                        temp = rand_temp();
                    end
                    queue_check(d, hr, mn, TEMP_W'(temp));
                    phase_count++;
                end
            end
            wait_idle();
        end

        if (fail_count == 0 && expected_status.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/sht_pkg.sv
design/sht_ctrl.sv
design/sht_dp.sv
design/scheduled_hysteresis_thermostat_top.sv
tb/sv/scheduled_hysteresis_thermostat_top_tb.sv
